FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the sprite row block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is never disabled
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/setr_pkg.sv
// Package of the sprite row block: types, decode constants and field widths.
`default_nettype none

package setr_pkg;

   // Field widths
   localparam int CODE_W = 16;
   localparam int POSX_W = 9;
   localparam int POSY_W = 8;
   localparam int BANK_W = 5;
   localparam int REQ_W  = 48;
   localparam int RSP_W  = 40;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int POS_W  = 11;

   // Register index of the layout select
   localparam logic [0:0] REG_LAYOUT = 1'b0;

   // Layout codes
   localparam logic LAYOUT_FIRST = 1'b0;
   localparam logic LAYOUT_LATER = 1'b1;

   // Decode constants
   localparam logic [8:0]              X_WRAP_AT   = 9'h180;
   localparam logic signed [POS_W-1:0] X_WRAP_SUB  = 11'sd512;
   localparam logic signed [POS_W-1:0] X_OFS_FIRST = 11'sd16;
   localparam logic signed [POS_W-1:0] X_OFS_LATER = -11'sd8;
   localparam logic signed [POS_W-1:0] X_LIMIT     = 11'sd336;
   localparam logic signed [POS_W-1:0] Y_BASE_FIRST = 11'sd264;
   localparam logic signed [POS_W-1:0] Y_HIGH_FIRST = 11'sd256;
   localparam logic signed [POS_W-1:0] Y_BASE_LATER = 11'sd519;
   localparam logic signed [POS_W-1:0] Y_LIMIT     = 11'sd256;
   localparam logic signed [POS_W-1:0] Y_LAST_FROM = 11'sd240;
   localparam logic signed [POS_W-1:0] ROW_PITCH   = 11'sd16;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic entry_visible;
      logic last_step;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/setr_ctrl.sv
// Controller of the sprite row block: idle / run sequencing of one entry.
`default_nettype none

module setr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire setr_pkg::status_type status,
   output setr_pkg::cmd_type        cmd
);

   setr_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= setr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         setr_pkg::ST_IDLE: begin
            if (req_tvalid && status.entry_visible) state_in = setr_pkg::ST_RUN;
         end
         setr_pkg::ST_RUN: begin
            if (status.out_free && status.last_step) state_in = setr_pkg::ST_IDLE;
         end
         default: state_in = setr_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         setr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         setr_pkg::ST_RUN: begin
            cmd.step = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/setr_dpath.sv
// Datapath of the sprite row block: entry decode, row walker and output register.
`default_nettype none

module setr_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          layout,
   input  wire logic [setr_pkg::REQ_W-1:0]    req_tdata,
   input  wire setr_pkg::cmd_type             cmd,
   output setr_pkg::status_type               status,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [setr_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int PW = setr_pkg::POS_W;

   logic [15:0] word_y, word_x;
   logic [setr_pkg::CODE_W-1:0] base_code;

   logic signed [PW-1:0] x_raw, x_wrap, x_dec;
   logic signed [PW-1:0] bottom, height, top;
   logic [2:0] rows_m1;
   logic       flip_dec;

   // Row walker
   logic signed [PW-1:0]        y_ff, y_in;
   logic [setr_pkg::CODE_W-1:0] code_ff, code_in;
   logic [2:0]                  idx_ff, idx_in, rows_m1_ff, rows_m1_in;
   logic [setr_pkg::POSX_W-1:0] x_ff, x_in;
   logic [setr_pkg::BANK_W-1:0] bank_ff, bank_in;
   logic                        flip_ff, flip_in;

   // Output register
   logic                        out_valid_ff, out_valid_in;
   logic                        out_load;
   logic [setr_pkg::CODE_W-1:0] out_code_ff;
   logic [setr_pkg::POSX_W-1:0] out_x_ff;
   logic [setr_pkg::POSY_W-1:0] out_y_ff;
   logic [setr_pkg::BANK_W-1:0] out_bank_ff;
   logic                        out_flip_ff, out_last_ff;
   logic                        row_visible, row_last;

   assign word_y    = req_tdata[15:0];
   assign base_code = req_tdata[31:16];
   assign word_x    = req_tdata[47:32];

   // Decode x: 9-bit value wrapped negative, then layout offset
   always_comb begin
      x_raw  = $signed({2'b00, word_x[8:0]});
      x_wrap = (word_x[8:0] >= setr_pkg::X_WRAP_AT) ? x_raw - setr_pkg::X_WRAP_SUB : x_raw;
      x_dec  = x_wrap + ((layout == setr_pkg::LAYOUT_FIRST) ? setr_pkg::X_OFS_FIRST
                                                           : setr_pkg::X_OFS_LATER);
   end

   // Decode height and top row y
   always_comb begin
      unique case (word_y[10:9])
         2'd0: begin height = 11'sd16;  rows_m1 = 3'd0; end
         2'd1: begin height = 11'sd32;  rows_m1 = 3'd1; end
         2'd2: begin height = 11'sd64;  rows_m1 = 3'd3; end
         2'd3: begin height = 11'sd128; rows_m1 = 3'd7; end
         default: begin height = 11'sd16; rows_m1 = 3'd0; end
      endcase
      if (layout == setr_pkg::LAYOUT_FIRST) begin
         bottom = setr_pkg::Y_BASE_FIRST - $signed({3'b000, word_y[7:0]})
                  + (word_y[8] ? setr_pkg::Y_HIGH_FIRST : 11'sd0);
         flip_dec = 1'b0;
      end else begin
         bottom = setr_pkg::Y_BASE_LATER - $signed({2'b00, word_y[8:0]});
         flip_dec = word_y[13];
      end
      top = bottom - height;
   end

   // Current row checks
   assign row_visible = (y_ff > 11'sd0) && (y_ff < setr_pkg::Y_LIMIT);
   assign row_last    = (idx_ff == rows_m1_ff) || (y_ff >= setr_pkg::Y_LAST_FROM);
   assign out_load    = cmd.step && row_visible;

   assign status.entry_visible = (x_dec > 11'sd0) && (x_dec < setr_pkg::X_LIMIT);
   assign status.last_step     = (idx_ff == rows_m1_ff);
   assign status.out_free      = !out_valid_ff || rsp_tready;

   // Walker next values
   always_comb begin
      y_in       = y_ff;
      code_in    = code_ff;
      idx_in     = idx_ff;
      rows_m1_in = rows_m1_ff;
      x_in       = x_ff;
      bank_in    = bank_ff;
      flip_in    = flip_ff;
      if (cmd.load) begin
         y_in       = top;
         code_in    = base_code;
         idx_in     = 3'd0;
         rows_m1_in = rows_m1;
         x_in       = x_dec[setr_pkg::POSX_W-1:0];
         bank_in    = {1'b1, word_x[12:9]};
         flip_in    = flip_dec;
      end else if (cmd.step) begin
         y_in    = y_ff + setr_pkg::ROW_PITCH;
         code_in = code_ff + 16'd1;
         idx_in  = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      y_ff       <= y_in;
      code_ff    <= code_in;
      x_ff       <= x_in;
      bank_ff    <= bank_in;
      flip_ff    <= flip_in;
      rows_m1_ff <= rows_m1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_code_ff <= code_ff;
         out_x_ff    <= x_ff;
         out_y_ff    <= y_ff[setr_pkg::POSY_W-1:0];
         out_bank_ff <= bank_ff;
         out_flip_ff <= flip_ff;
         out_last_ff <= row_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_flip_ff, out_bank_ff, out_y_ff, out_x_ff, out_code_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/sprite_entry_to_tile_rows.sv
// Top level of the sprite row block: layout register, controller and datapath.
//
//  channel   direction  payload (lowest bit up)
//  req_      in         word_y[15:0] base_code[31:16] word_x[47:32]
//  rsp_      out        row_code pos_x pos_y palette_bank mirror_x, tlast = last_row
//  csr_      in/out     register 0 at byte address 0: layout_variant
//
// An entry is taken while idle; a visible entry then walks its 1, 2, 4 or 8
// rows, one row per cycle while the output is free, with the input held off.
// An entry whose x is off screen is taken and gives nothing.
// The row walker waits while the output register holds an untaken item.
// Reset is synchronous and clears the layout select and all control state.
`default_nettype none

module sprite_entry_to_tile_rows (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // word_y[15:0], base_code[31:16], word_x[47:32]
   input  wire logic [setr_pkg::REQ_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // row_code[15:0], pos_x[24:16], pos_y[32:25], palette_bank[37:33],
   // mirror_x[38], zero[39]
   output logic [setr_pkg::RSP_W-1:0]          rsp_tdata,
   output logic                                rsp_tlast,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [setr_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [setr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [setr_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);

   logic layout_ff, layout_in;
   logic csr_write;
   setr_pkg::cmd_type    cmd;
   setr_pkg::status_type status;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      layout_in = layout_ff;
      if (csr_write && (csr_paddr[2] == setr_pkg::REG_LAYOUT)) layout_in = csr_pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= setr_pkg::LAYOUT_FIRST;
      end else begin
         layout_ff <= layout_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == setr_pkg::REG_LAYOUT)
                       ? {{(setr_pkg::CSR_DW-1){1'b0}}, layout_ff} : '0;

   setr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   setr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .layout     (layout_ff),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/setr_checker.sv
// Port-level checker of the sprite row block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module setr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [setr_pkg::RSP_W-1:0] rsp_tdata,
   input wire logic                       rsp_tlast
);

   // A stalled result item holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Palette bank always has its top bit set
   `ASSERT_SAME(a_bank_high, clock, reset, rsp_tvalid, rsp_tdata[37] == 1'b1)

   // Row y is never zero
   `ASSERT_SAME(a_y_nonzero, clock, reset, rsp_tvalid, rsp_tdata[32:25] != 8'd0)

   // Tile x lies on screen
   `ASSERT_SAME(a_x_range, clock, reset, rsp_tvalid, (rsp_tdata[24:16] != 9'd0) && (rsp_tdata[24:16] < 9'd336))

   // No result item straight after reset
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind sprite_entry_to_tile_rows setr_checker u_setr_checker (.*);

`default_nettype wire

FILE: verif/tb_sprite_entry_to_tile_rows.sv
// Self-checking testbench of the sprite entry to tile rows block.
`timescale 1ns / 100ps

module tb_sprite_entry_to_tile_rows;

   // One tile command as the result channel carries it
   typedef struct packed {
      logic [setr_pkg::CODE_W-1:0] row_code;
      logic [setr_pkg::POSX_W-1:0] pos_x;
      logic [setr_pkg::POSY_W-1:0] pos_y;
      logic [setr_pkg::BANK_W-1:0] palette_bank;
      logic                        mirror_x;
      logic                        last_row;
   } row_item_type;

   // One row of the directed table; typed_n of USE_MODEL hands it to the predictor
   typedef struct packed {
      logic              layout;
      logic [15:0]       word_y;
      logic [15:0]       base_code;
      logic [15:0]       word_x;
      logic [3:0]        typed_n;
      row_item_type      typed_row;
   } entry_row_type;

   localparam logic [3:0]                  USE_MODEL   = 4'hf;
   localparam logic [setr_pkg::CSR_AW-1:0] ADDR_LAYOUT =
      setr_pkg::CSR_AW'(4 * setr_pkg::REG_LAYOUT);
   localparam logic [setr_pkg::CSR_AW-1:0] ADDR_SPARE  = setr_pkg::CSR_AW'(4);
   localparam int                          SETTLE_CYC  = 20;
   localparam int                          HOLD_CYC    = 80;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [setr_pkg::REQ_W-1:0]    req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [setr_pkg::RSP_W-1:0]    rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [setr_pkg::CSR_AW-1:0]   csr_paddr;
   logic [setr_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [setr_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   row_item_type  rows_due[$];
   entry_row_type entry_table[$];
   logic          layout_now;
   int            mismatch_count;
   int            idle_pct;
   bit            hold_req;
   int            hold_left;

   sprite_entry_to_tile_rows u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Tile rows of one entry under the current layout
   task automatic predict_rows(input logic [15:0] wy, input logic [15:0] code,
                               input logic [15:0] wx);
      int            rows;
      int            x;
      int            yb;
      int            top;
      int            y;
      logic [4:0]    bank;
      logic          flip;
      row_item_type  item;
      row_item_type  found[$];
      rows = 1 << wy[10:9];
      x = wx[8:0];
      // 384..511 stand for negative positions
      if (x >= 384) x -= 512;
      bank = 5'd16 + wx[12:9];
      if (layout_now == setr_pkg::LAYOUT_FIRST) begin
         yb  = 256 - (int'(wy[7:0]) - (wy[8] ? 256 : 0));
         top = yb - rows * 16 + 8;
         x   += 16;
         flip = 1'b0;
      end else begin
         yb  = 511 - int'(wy[8:0]) + 8;
         top = yb - rows * 16;
         x   -= 8;
         flip = wy[13];
      end
      if (x > 0 && x < 336) begin
         for (int i = 0; i < rows; i++) begin
            y = top + i * 16;
            if (y > 0 && y < 256) begin
               item = '{code + 16'(i), 9'(x), 8'(y), bank, flip, 1'b0};
               found.push_back(item);
            end
         end
      end
      if (found.size() > 0) found[found.size() - 1].last_row = 1'b1;
      foreach (found[k]) rows_due.push_back(found[k]);
   endtask

   // Offer one entry, called at a falling edge; expectations go in on acceptance
   task automatic send_entry(input logic [15:0] wy, input logic [15:0] code,
                             input logic [15:0] wx, input logic [3:0] typed_n,
                             input row_item_type typed_row);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {wx, code, wy};
      do @(posedge clock); while (!req_tready);
      if (typed_n == USE_MODEL) predict_rows(wy, code, wx);
      else if (typed_n == 4'd1) rows_due.push_back(typed_row);
      @(negedge clock);
   endtask

   // Stop offering, wait for the outstanding rows, then let the walker settle
   task automatic drain_rows;
      int waited;
      waited = 0;
      req_tvalid = 1'b0;
      while (rows_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
      @(negedge clock);
   endtask

   // APB write, setup then access, called at a falling edge
   task automatic write_reg(input logic [setr_pkg::CSR_AW-1:0] addr,
                            input logic [setr_pkg::CSR_DW-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_LAYOUT) layout_now = data[0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // APB read of the layout register, checked against the local copy
   task automatic check_layout_reg;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = ADDR_LAYOUT;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {{(setr_pkg::CSR_DW-1){1'b0}}, layout_now}) begin
         $error("layout_variant: expected %0h, got %0h", layout_now, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Change layout between phases with junk in the upper bits
   task automatic set_layout(input logic lay);
      drain_rows();
      write_reg(ADDR_LAYOUT, ($urandom() & ~32'h1) | {31'b0, lay});
      check_layout_reg();
   endtask

   task automatic add_row(input logic lay, input logic [15:0] wy, input logic [15:0] code,
                          input logic [15:0] wx, input logic [3:0] n, input row_item_type r);
      entry_row_type e;
      e = '{lay, wy, code, wx, n, r};
      entry_table.push_back(e);
   endtask

   // Receiver: random stalls, plus one long counted hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= idle_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      row_item_type got;
      row_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[24:16], rsp_tdata[32:25],
                 rsp_tdata[37:33], rsp_tdata[38], rsp_tlast};
         if (rows_due.size() == 0) begin
            $error("unexpected tile row: row_code %0h", got.row_code);
            mismatch_count++;
         end else begin
            want = rows_due.pop_front();
            if (got.row_code !== want.row_code) begin
               $error("row_code: expected %0h, got %0h", want.row_code, got.row_code);
               mismatch_count++;
            end
            if (got.pos_x !== want.pos_x) begin
               $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
               mismatch_count++;
            end
            if (got.pos_y !== want.pos_y) begin
               $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
               mismatch_count++;
            end
            if (got.palette_bank !== want.palette_bank) begin
               $error("palette_bank: expected %0d, got %0d", want.palette_bank,
                      got.palette_bank);
               mismatch_count++;
            end
            if (got.mirror_x !== want.mirror_x) begin
               $error("mirror_x: expected %0b, got %0b", want.mirror_x, got.mirror_x);
               mismatch_count++;
            end
            if (got.last_row !== want.last_row) begin
               $error("last_row: expected %0b, got %0b", want.last_row, got.last_row);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      row_item_type  none;
      entry_row_type e;
      logic          lay;
      logic [15:0]   wy;
      logic [15:0]   wx;
      logic [15:0]   code;
      logic [8:0]    raw_x;
      int            xf;

      none           = '0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      layout_now     = setr_pkg::LAYOUT_FIRST;
      mismatch_count = 0;
      idle_pct       = 21;
      hold_req       = 1'b0;
      hold_left      = 0;

      // Directed entries: layout, word_y, base_code, word_x, typed count, typed row
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0000, 16'hffff, 16'h0000, 4'd1,
              '{16'hffff, 9'd16, 8'd248, 5'd16, 1'b0, 1'b1});
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0000, 16'h0000, 16'h1fff, 4'd1,
              '{16'h0000, 9'd15, 8'd248, 5'd31, 1'b0, 1'b1});
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0000, 16'h1234, 16'h013f, 4'd1,
              '{16'h1234, 9'd335, 8'd248, 5'd16, 1'b0, 1'b1});
      // x lands on the right edge, then on zero, then just inside
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0000, 16'h0001, 16'h0140, 4'd0, none);
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0000, 16'h0002, 16'h01f0, 4'd0, none);
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0000, 16'h0003, 16'h01f1, 4'd1,
              '{16'h0003, 9'd1, 8'd248, 5'd16, 1'b0, 1'b1});
      // far left after the negative wrap
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0000, 16'h0004, 16'h0180, 4'd0, none);
      // no visible row: above the top, and pushed down by y bit 8
      add_row(setr_pkg::LAYOUT_FIRST, 16'h00ff, 16'h0005, 16'h0040, 4'd0, none);
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0100, 16'h0006, 16'h0040, 4'd0, none);
      // eight rows with code wrap; ignored bits and flip in layout 0
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0680, 16'hfffc, 16'h0040, USE_MODEL, none);
      add_row(setr_pkg::LAYOUT_FIRST, 16'hfa40, 16'h0100, 16'he0a0, USE_MODEL, none);
      add_row(setr_pkg::LAYOUT_FIRST, 16'h0410, 16'h0200, 16'h1e64, USE_MODEL, none);
      // two rows, only the lower one on screen
      add_row(setr_pkg::LAYOUT_FIRST, 16'h02e8, 16'h0300, 16'h0055, USE_MODEL, none);
      add_row(setr_pkg::LAYOUT_LATER, 16'h0000, 16'h0010, 16'h0009, 4'd0, none);
      add_row(setr_pkg::LAYOUT_LATER, 16'h0100, 16'h0020, 16'h0009, 4'd1,
              '{16'h0020, 9'd1, 8'd247, 5'd16, 1'b0, 1'b1});
      add_row(setr_pkg::LAYOUT_LATER, 16'h0100, 16'h0021, 16'h0008, 4'd0, none);
      add_row(setr_pkg::LAYOUT_LATER, 16'h0100, 16'h0022, 16'h0157, 4'd1,
              '{16'h0022, 9'd335, 8'd247, 5'd16, 1'b0, 1'b1});
      add_row(setr_pkg::LAYOUT_LATER, 16'h0100, 16'h0023, 16'h0158, 4'd0, none);
      // flipped eight-row strip, top bank, code wrap
      add_row(setr_pkg::LAYOUT_LATER, 16'h2700, 16'hfff9, 16'h1e20, USE_MODEL, none);
      add_row(setr_pkg::LAYOUT_LATER, 16'h01ff, 16'h0030, 16'h0020, 4'd0, none);
      add_row(setr_pkg::LAYOUT_LATER, 16'hd5f0, 16'h0040, 16'hf040, USE_MODEL, none);
      add_row(setr_pkg::LAYOUT_LATER, 16'h0180, 16'h0050, 16'h0180, 4'd0, none);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register after reset; a write to an unused index changes nothing
      check_layout_reg();
      write_reg(ADDR_SPARE, 32'hffff_ffff);
      check_layout_reg();

      // Directed table
      foreach (entry_table[i]) begin
         e = entry_table[i];
         if (e.layout != layout_now) set_layout(e.layout);
         send_entry(e.word_y, e.base_code, e.word_x, e.typed_n, e.typed_row);
      end

      // Random phases, each opened with a layout write while idle
      for (int phase = 0; phase < 6; phase++) begin
         lay = (phase < 5) ? phase[0] : 1'($urandom_range(1));
         set_layout(lay);
         idle_pct = (phase == 2) ? 0 : 21;
         if (phase == 3) hold_req = 1'b1;
         for (int n = 0; n < 50; n++) begin
            code = 16'($urandom());
            if ($urandom_range(99) < 70) begin
               // well-formed: x on screen, layout 0 kept clear of y bit 8
               xf    = $urandom_range(335, 1);
               raw_x = (layout_now == setr_pkg::LAYOUT_FIRST) ? 9'(xf - 16) : 9'(xf + 8);
               wx    = {7'($urandom()), raw_x};
               wy    = 16'($urandom());
               if (layout_now == setr_pkg::LAYOUT_FIRST) wy[8] = 1'b0;
            end else begin
               wx = 16'($urandom());
               wy = 16'($urandom());
            end
            send_entry(wy, code, wx, USE_MODEL, none);
         end
      end

      idle_pct = 21;
      drain_rows();
      if (rows_due.size() != 0) begin
         $error("tile rows never arrived: %0d outstanding", rows_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
